// File: rtl/core/owadc_pkg.sv
// ----------------------------------------------------------------------------
// owadc_pkg: shared types, codes and functions of the 1-Wire ADC slave engine
// Holds bus event codes, protocol command bytes, register indexes, reset
// values of the configuration registers and the CRC-16 byte function.
// ----------------------------------------------------------------------------
package owadc_pkg;

  // Bus event codes carried on the input tuser field.
  localparam logic [1:0] CMD_BUS_RESET = 2'd0;
  localparam logic [1:0] CMD_WRITE     = 2'd1;
  localparam logic [1:0] CMD_READ      = 2'd2;
  localparam logic [1:0] CMD_TICK      = 2'd3;

  // ROM and function command bytes.
  localparam logic [7:0] ROM_READ   = 8'h33;
  localparam logic [7:0] ROM_MATCH  = 8'h55;
  localparam logic [7:0] ROM_SKIP   = 8'hCC;
  localparam logic [7:0] FN_WRITE   = 8'h55;
  localparam logic [7:0] FN_READ    = 8'hAA;
  localparam logic [7:0] FN_CONVERT = 8'h3C;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ROM_ID      = 3'd0;
  localparam logic [2:0] CFG_CONV_TICKS  = 3'd1;
  localparam logic [2:0] CFG_SWEEP_TICKS = 3'd2;
  localparam logic [2:0] CFG_SWEEP_MIN   = 3'd3;
  localparam logic [2:0] CFG_SWEEP_MAX   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [63:0] ROM_ID_RST      = 64'h9E00_0000_0086_1C20;
  localparam logic [15:0] CONV_TICKS_RST  = 16'd15;
  localparam logic [15:0] SWEEP_TICKS_RST = 16'd500;
  localparam logic [12:0] SWEEP_MIN_RST   = 13'd200;
  localparam logic [12:0] SWEEP_MAX_RST   = 13'd300;

  // Swept level limits and reset level.
  localparam logic [12:0] LEVEL_CAP = 13'd6553;
  localparam logic [12:0] LEVEL_RST = 13'd200;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Control of the shared CRC unit.
  typedef struct packed {
    logic       clr;
    logic       en;
    logic [7:0] data;
  } crc_ctrl_t;

  // One byte through the reflected CRC-16, one bit per loop step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Content of a data store entry after reset: ADC reading 2000, the reset level
  // times ten, as little-endian pairs, then two fixed setup bytes, zero elsewhere.
  function automatic logic [7:0] store_init(input logic [15:0] idx);
    logic [7:0] v;
    if (idx < 16'd8) begin
      v = idx[0] ? 8'h07 : 8'hD0;
    end else if (idx == 16'd8) begin
      v = 8'h08;
    end else if (idx == 16'd9) begin
      v = 8'h01;
    end else begin
      v = 8'h00;
    end
    return v;
  endfunction

endpackage

// File: rtl/core/owadc_crc.sv
// ----------------------------------------------------------------------------
// owadc_crc: shared CRC-16 unit
// Accumulates one byte per enabled cycle into a running CRC; clear restarts
// the accumulation at zero.
// ----------------------------------------------------------------------------
module owadc_crc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  owadc_pkg::crc_ctrl_t  ctrl_i,
  output logic [15:0]           crc_o
);
  import owadc_pkg::*;

  logic [15:0] crc_q;
  logic [15:0] crc_d;

  always_comb begin
    if (ctrl_i.clr) begin
      crc_d = 16'h0000;
    end else if (ctrl_i.en) begin
      crc_d = crc_byte(crc_q, ctrl_i.data);
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// File: rtl/core/owadc_store.sv
// ----------------------------------------------------------------------------
// owadc_store: data store of the slave
// One write port and one registered read port. Entries never written since
// reset read as their reset contents, tracked by one valid bit per entry.
// ----------------------------------------------------------------------------
module owadc_store #(
  parameter int STORE_BYTES = 24,
  parameter int AW          = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  import owadc_pkg::*;

  logic [7:0]             mem_q [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_q;
  logic [7:0]             rd_data_q;
  logic                   rd_vld_q;
  logic [AW-1:0]          rd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[raddr_i];
      rd_vld_q  <= vld_q[raddr_i];
      rd_addr_q <= raddr_i;
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : store_init({{(16-AW){1'b0}}, rd_addr_q});

endmodule

// File: rtl/core/onewire_adc_slave_transaction_engine.sv
// ----------------------------------------------------------------------------
// Throughput: one item at a time, taken once the sequencer is back in idle; set by
// the shared CRC unit (one byte per cycle while the output is free) and the store
// read port (a request state, then a data state, for each byte read).
// Reset is asynchronous and active low; the store needs no clearing pass.
// ----------------------------------------------------------------------------
// onewire_adc_slave_transaction_engine: byte-level 1-Wire slave of a quad ADC
// A small sequencer steps bus events through the shared CRC unit and the
// data store, and hands result bytes to an output register.
// ----------------------------------------------------------------------------
module onewire_adc_slave_transaction_engine #(
  parameter int STORE_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_out
  output logic        m_axis_tlast,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  import owadc_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  // Protocol phase, as seen between bus events.
  typedef enum logic [3:0] {
    PH_IDLE, PH_ROM, PH_MATCH, PH_FUNC, PH_WR_LO, PH_WR_HI, PH_WR_DATA,
    PH_RD_LO, PH_RD_HI, PH_CV_CH, PH_CV_RC, PH_POLL
  } phase_e;

  // Sequencer states that work through one item.
  typedef enum logic [3:0] {
    S_IDLE, S_ONE, S_ROMID, S_CRC, S_WEMIT, S_RREQ, S_RDATA, S_REMIT,
    S_CEMIT, S_SWEEP, S_MUL, S_LOAD
  } state_e;

  // What the CRC pass belongs to.
  typedef enum logic [1:0] {
    OP_WR, OP_RD, OP_CV
  } op_e;

  // Configuration registers.
  logic [63:0] rom_id_q;
  logic [15:0] conv_ticks_q;
  logic [15:0] sweep_ticks_q;
  logic [12:0] sweep_min_q;
  logic [12:0] sweep_max_q;

  // Protocol and sequencer state.
  state_e      state_q;
  phase_e      phase_q;
  op_e         op_q;
  logic [2:0]  cnt_q;
  logic [2:0]  feed_n_q;
  logic [7:0]  feed_q [4];
  logic [2:0]  byte_index_q;
  logic        id_matches_q;
  logic [15:0] mem_address_q;
  logic [15:0] rd_base_q;
  logic [7:0]  addr_low_held_q;
  logic [7:0]  channel_held_q;
  logic [7:0]  one_byte_q;
  logic        rd_oob_q;

  // Sweep and conversion timing.
  logic [12:0] sweep_level_q;
  logic        sweep_rising_q;
  logic [15:0] sweep_count_q;
  logic [15:0] conv_count_q;
  logic        conv_finished_q;
  logic [15:0] raw_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic [1:0]  cmd;
  logic [7:0]  din;
  logic [15:0] crc;
  crc_ctrl_t   crc_ctrl;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;

  logic [16:0] rd_ptr;
  logic        rd_in_range;
  logic [7:0]  rd_byte;
  logic [7:0]  rom_byte;
  logic        id_match_d;
  logic [16:0] sweep_inc;
  logic [15:0] conv_count_d;
  logic        poll_done;
  logic [12:0] level_d;
  logic        rising_d;
  logic [15:0] raw_d;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cmd           = s_axis_tuser;
  assign din           = s_axis_tdata;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // A result byte is loaded into the output register in this cycle.
  always_comb begin
    out_load = 1'b0;
    unique case (state_q) inside
      S_ONE, S_ROMID, S_WEMIT, S_RDATA, S_REMIT, S_CEMIT: out_load = out_free;
      default: ;
    endcase
  end

  // Identity byte selected by the match position.
  assign rom_byte   = rom_id_q[{byte_index_q, 3'b000} +: 8];
  assign id_match_d = id_matches_q && (din == rom_byte);

  // Read memory walks eight addresses from the base without wrapping.
  assign rd_ptr      = {1'b0, rd_base_q} + {14'd0, cnt_q};
  assign rd_in_range = (rd_ptr < 17'(STORE_BYTES));
  assign rd_byte     = rd_oob_q ? BYTE_ONES : st_rdata;

  // Tick arithmetic.
  assign sweep_inc    = {1'b0, sweep_count_q} + 17'd1;
  assign conv_count_d = (conv_count_q != 16'hFFFF) ? (conv_count_q + 16'd1) : conv_count_q;
  assign poll_done    = conv_finished_q || (conv_count_q >= conv_ticks_q);

  // One step of the triangular sweep; the lower turning test wins.
  always_comb begin
    if (sweep_rising_q) begin
      level_d = (sweep_level_q < LEVEL_CAP) ? (sweep_level_q + 13'd1) : sweep_level_q;
    end else begin
      level_d = (sweep_level_q != 13'd0) ? (sweep_level_q - 13'd1) : sweep_level_q;
    end
    if (level_d <= sweep_min_q) begin
      rising_d = 1'b1;
    end else if (level_d >= sweep_max_q) begin
      rising_d = 1'b0;
    end else begin
      rising_d = sweep_rising_q;
    end
  end

  // The ADC reading is the level times ten, as eight plus two; the level cap
  // keeps it within 16 bits.
  assign raw_d = {sweep_level_q, 3'b000} + {2'b00, sweep_level_q, 1'b0};

  // Shared CRC unit control: restarted with every item, fed from the held
  // header bytes and then from the store bytes as they leave.
  always_comb begin
    crc_ctrl.clr  = accept;
    crc_ctrl.en   = 1'b0;
    crc_ctrl.data = feed_q[cnt_q[1:0]];
    if (state_q == S_CRC) begin
      crc_ctrl.en = 1'b1;
    end else if (state_q == S_RDATA) begin
      crc_ctrl.en   = out_free;
      crc_ctrl.data = rd_byte;
    end
  end

  // Store ports: master data bytes in the accept cycle, ADC bytes during the
  // load sweep, reads during read memory.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = mem_address_q[AW-1:0];
    st_wdata = din;
    if (accept && (cmd == CMD_WRITE) && (phase_q == PH_WR_DATA) &&
        (mem_address_q < 16'(STORE_BYTES))) begin
      st_we = 1'b1;
    end else if (state_q == S_LOAD) begin
      st_we    = 1'b1;
      st_waddr = AW'(cnt_q);
      st_wdata = cnt_q[0] ? raw_q[15:8] : raw_q[7:0];
    end
    st_re    = (state_q == S_RREQ) && rd_in_range;
    st_raddr = rd_ptr[AW-1:0];
  end

  owadc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  owadc_store #(
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // The user must write configuration only while the engine is idle; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_id_q      <= ROM_ID_RST;
      conv_ticks_q  <= CONV_TICKS_RST;
      sweep_ticks_q <= SWEEP_TICKS_RST;
      sweep_min_q   <= SWEEP_MIN_RST;
      sweep_max_q   <= SWEEP_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROM_ID:      rom_id_q      <= cfg_data_i;
        CFG_CONV_TICKS:  conv_ticks_q  <= cfg_data_i[15:0];
        CFG_SWEEP_TICKS: sweep_ticks_q <= cfg_data_i[15:0];
        CFG_SWEEP_MIN:   sweep_min_q   <= cfg_data_i[12:0];
        CFG_SWEEP_MAX:   sweep_max_q   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Header bytes for the CRC pass are held here; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept && (cmd == CMD_WRITE)) begin
      unique case (phase_q)
        PH_WR_DATA: begin
          feed_q[0] <= FN_WRITE;
          feed_q[1] <= mem_address_q[7:0];
          feed_q[2] <= mem_address_q[15:8];
          feed_q[3] <= din;
        end
        PH_RD_HI: begin
          feed_q[0] <= FN_READ;
          feed_q[1] <= addr_low_held_q;
          feed_q[2] <= din;
          feed_q[3] <= BYTE_ZERO;
        end
        PH_CV_RC: begin
          feed_q[0] <= FN_CONVERT;
          feed_q[1] <= channel_held_q;
          feed_q[2] <= din;
          feed_q[3] <= BYTE_ZERO;
        end
        default: ;
      endcase
    end
  end

  // Sequencer, protocol state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      phase_q         <= PH_IDLE;
      op_q            <= OP_WR;
      cnt_q           <= 3'd0;
      feed_n_q        <= 3'd0;
      byte_index_q    <= 3'd0;
      id_matches_q    <= 1'b1;
      mem_address_q   <= 16'd0;
      rd_base_q       <= 16'd0;
      addr_low_held_q <= 8'd0;
      channel_held_q  <= 8'd0;
      one_byte_q      <= 8'd0;
      rd_oob_q        <= 1'b0;
      sweep_level_q   <= LEVEL_RST;
      sweep_rising_q  <= 1'b1;
      sweep_count_q   <= 16'd0;
      conv_count_q    <= 16'd0;
      conv_finished_q <= 1'b0;
      raw_q           <= 16'd0;
      out_valid_q     <= 1'b0;
      out_data_q      <= 8'd0;
      out_last_q      <= 1'b0;
    end else begin
      // The output register empties when taken, unless a new byte loads.
      if (m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q <= 3'd0;
            unique case (cmd)
              CMD_BUS_RESET: begin
                phase_q      <= PH_ROM;
                byte_index_q <= 3'd0;
              end
              CMD_READ: begin
                // Polling reads report conversion status; any other read
                // gets an idle bus.
                if (phase_q == PH_POLL) begin
                  conv_finished_q <= poll_done;
                  one_byte_q      <= poll_done ? BYTE_ONES : BYTE_ZERO;
                  if (poll_done) begin
                    phase_q <= PH_IDLE;
                  end
                end else begin
                  one_byte_q <= BYTE_ONES;
                end
                state_q <= S_ONE;
              end
              CMD_TICK: begin
                if (sweep_inc >= {1'b0, sweep_ticks_q}) begin
                  sweep_count_q <= 16'd0;
                  state_q       <= S_SWEEP;
                end else begin
                  sweep_count_q <= sweep_inc[15:0];
                end
                conv_count_q <= conv_count_d;
                if (conv_count_d >= conv_ticks_q) begin
                  conv_finished_q <= 1'b1;
                end
              end
              CMD_WRITE: begin
                unique case (phase_q)
                  PH_ROM: begin
                    if (din == ROM_READ) begin
                      phase_q <= PH_IDLE;
                      state_q <= S_ROMID;
                    end else if (din == ROM_MATCH) begin
                      byte_index_q <= 3'd0;
                      id_matches_q <= 1'b1;
                      phase_q      <= PH_MATCH;
                    end else if (din == ROM_SKIP) begin
                      phase_q <= PH_FUNC;
                    end else begin
                      phase_q <= PH_IDLE;
                    end
                  end
                  PH_MATCH: begin
                    id_matches_q <= id_match_d;
                    if (byte_index_q == 3'd7) begin
                      byte_index_q <= 3'd0;
                      phase_q      <= id_match_d ? PH_FUNC : PH_IDLE;
                    end else begin
                      byte_index_q <= byte_index_q + 3'd1;
                    end
                  end
                  PH_FUNC: begin
                    if (din == FN_WRITE) begin
                      phase_q <= PH_WR_LO;
                    end else if (din == FN_READ) begin
                      phase_q <= PH_RD_LO;
                    end else if (din == FN_CONVERT) begin
                      phase_q <= PH_CV_CH;
                    end else begin
                      phase_q <= PH_IDLE;
                    end
                  end
                  PH_WR_LO: begin
                    addr_low_held_q <= din;
                    phase_q         <= PH_WR_HI;
                  end
                  PH_WR_HI: begin
                    mem_address_q <= {din, addr_low_held_q};
                    phase_q       <= PH_WR_DATA;
                  end
                  PH_WR_DATA: begin
                    // The data byte goes through the store port in this cycle.
                    mem_address_q <= mem_address_q + 16'd1;
                    feed_n_q      <= 3'd4;
                    op_q          <= OP_WR;
                    state_q       <= S_CRC;
                  end
                  PH_RD_LO: begin
                    addr_low_held_q <= din;
                    phase_q         <= PH_RD_HI;
                  end
                  PH_RD_HI: begin
                    rd_base_q <= {din, addr_low_held_q};
                    feed_n_q  <= 3'd3;
                    op_q      <= OP_RD;
                    phase_q   <= PH_IDLE;
                    state_q   <= S_CRC;
                  end
                  PH_CV_CH: begin
                    channel_held_q <= din;
                    phase_q        <= PH_CV_RC;
                  end
                  PH_CV_RC: begin
                    conv_count_q    <= 16'd0;
                    conv_finished_q <= 1'b0;
                    feed_n_q        <= 3'd3;
                    op_q            <= OP_CV;
                    phase_q         <= PH_POLL;
                    state_q         <= S_CRC;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end

        S_ONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= one_byte_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_ROMID: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= rom_id_q[{cnt_q, 3'b000} +: 8];
            out_last_q  <= (cnt_q == 3'd7);
            cnt_q       <= cnt_q + 3'd1;
            if (cnt_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_CRC: begin
          // One header byte per cycle through the CRC unit.
          if (cnt_q == feed_n_q - 3'd1) begin
            cnt_q <= 3'd0;
            unique case (op_q)
              OP_WR:   state_q <= S_WEMIT;
              OP_RD:   state_q <= S_RREQ;
              OP_CV:   state_q <= S_CEMIT;
              default: state_q <= S_IDLE;
            endcase
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end

        S_WEMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= (cnt_q == 3'd2);
            if (cnt_q == 3'd0) begin
              out_data_q <= crc[7:0];
            end else if (cnt_q == 3'd1) begin
              out_data_q <= crc[15:8];
            end else begin
              out_data_q <= ~crc[7:0];
            end
            cnt_q <= cnt_q + 3'd1;
            if (cnt_q == 3'd2) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_RREQ: begin
          rd_oob_q <= !rd_in_range;
          state_q  <= S_RDATA;
        end

        S_RDATA: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= rd_byte;
            out_last_q  <= 1'b0;
            if (cnt_q == 3'd7) begin
              cnt_q   <= 3'd0;
              state_q <= S_REMIT;
            end else begin
              cnt_q   <= cnt_q + 3'd1;
              state_q <= S_RREQ;
            end
          end
        end

        S_REMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= (cnt_q == 3'd0) ? ~crc[7:0] : ~crc[15:8];
            out_last_q  <= (cnt_q == 3'd1);
            cnt_q       <= cnt_q + 3'd1;
            if (cnt_q == 3'd1) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_CEMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= (cnt_q == 3'd0) ? crc[7:0] : crc[15:8];
            out_last_q  <= (cnt_q == 3'd1);
            cnt_q       <= cnt_q + 3'd1;
            if (cnt_q == 3'd1) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_SWEEP: begin
          sweep_level_q  <= level_d;
          sweep_rising_q <= rising_d;
          state_q        <= S_MUL;
        end

        S_MUL: begin
          raw_q   <= raw_d;
          cnt_q   <= 3'd0;
          state_q <= S_LOAD;
        end

        S_LOAD: begin
          // Eight ADC bytes, one store write per cycle.
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/tb_onewire_adc_slave_transaction_engine.sv
// ----------------------------------------------------------------------------
// tb_onewire_adc_slave_transaction_engine: self-checking bench of the slave
// Feeds bus events (reset, written byte, read slot, timer tick) into the
// engine over the input stream and checks every reply byte against an
// in-bench model of the slave: ROM commands, memory write with CRC echo,
// memory read with CRC trailer, convert with polling, and the swept ADC level.
// ----------------------------------------------------------------------------
module tb_onewire_adc_slave_transaction_engine;
  import owadc_pkg::*;

  localparam int STORE_BYTES = 24;
  // Quiet cycles after the last reply before a register write or the end of
  // the run: covers the longest item (read memory) with margin.
  localparam int DRAIN_CYCLES = 32;
  // About 350 items in total. The limit leaves wide room for the work and the up
  // to ten replies of each item, even with every reply held off by receiver stalls.
  localparam int CYCLE_LIMIT = 200_000;

  // Sequencer phases of the slave as the bench models them.
  typedef enum logic [3:0] {
    SLV_IDLE, SLV_ROM_CMD, SLV_MATCH, SLV_FUNC_CMD, SLV_WADDR_LO, SLV_WADDR_HI,
    SLV_WDATA, SLV_RADDR_LO, SLV_RADDR_HI, SLV_CONV_CH, SLV_CONV_CTRL, SLV_POLL
  } slave_phase_e;

  // One reply byte as it should appear on the output stream.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_t;

  // One row of the directed part. A typed row carries its single reply byte
  // (with tlast set); other rows are checked against the model.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       typed;
    logic [7:0] typed_byte;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  // Model copy of the configuration registers.
  logic [63:0] cfg_rom_id;
  logic [15:0] cfg_conv_ticks;
  logic [15:0] cfg_sweep_ticks;
  logic [12:0] cfg_sweep_min;
  logic [12:0] cfg_sweep_max;

  // Model copy of the slave state.
  slave_phase_e sl_phase;
  logic [2:0]   sl_byte_idx;
  logic         sl_id_ok;
  logic [15:0]  sl_addr;
  logic [7:0]   sl_addr_lo;
  logic [7:0]   sl_channel;
  logic [7:0]   sl_store [STORE_BYTES];
  logic [12:0]  sl_level;
  logic         sl_rising;
  logic [16:0]  sl_sweep_cnt;
  logic [15:0]  sl_conv_cnt;
  logic         sl_conv_done;

  // Reply bytes predicted but not yet seen on the output stream, oldest first.
  reply_t reply_q [$];
  reply_t want;

  int  error_count;
  int  items_sent;
  int  replies_checked;
  int  reg_writes;
  int  cycle_count;
  // While set, neither side of the stream inserts idle cycles.
  bit  no_idle;

  stim_row_t directed_rows [28];

  onewire_adc_slave_transaction_engine #(
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] data_in
    .s_axis_tuser (s_axis_tuser),   // [1:0] command
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [7:0] data_out
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Reflected CRC-16, initial value supplied by the caller, one data bit per
  // step: the feedback bit is the low CRC bit combined with the next data bit.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // The four ADC channels hold ten times the swept level, little-endian.
  task automatic load_adc_bytes();
    logic [15:0] raw;
    raw = {3'b000, sl_level} * 16'd10;
    for (int k = 0; k < 8; k += 2) begin
      sl_store[k]     = raw[7:0];
      sl_store[k + 1] = raw[15:8];
    end
  endtask

  task automatic reset_slave_model();
    cfg_rom_id      = ROM_ID_RST;
    cfg_conv_ticks  = CONV_TICKS_RST;
    cfg_sweep_ticks = SWEEP_TICKS_RST;
    cfg_sweep_min   = SWEEP_MIN_RST;
    cfg_sweep_max   = SWEEP_MAX_RST;
    sl_phase     = SLV_IDLE;
    sl_byte_idx  = 3'd0;
    sl_id_ok     = 1'b1;
    sl_addr      = 16'h0000;
    sl_addr_lo   = 8'h00;
    sl_channel   = 8'h00;
    foreach (sl_store[i]) sl_store[i] = 8'h00;
    sl_level     = LEVEL_RST;
    load_adc_bytes();
    // Two fixed setup bytes follow the ADC channels.
    sl_store[8]  = 8'h08;
    sl_store[9]  = 8'h01;
    sl_rising    = 1'b1;
    sl_sweep_cnt = 17'd0;
    sl_conv_cnt  = 16'h0000;
    sl_conv_done = 1'b0;
  endtask

  // Advances the model by one accepted bus event and queues the reply bytes
  // that event causes, tlast on the final one.
  task automatic predict_reply(input logic [1:0] cmd, input logic [7:0] d);
    logic [7:0]  bytes_out [10];
    int          n;
    int          pos;
    logic [15:0] crc;
    logic [15:0] a;
    logic [7:0]  b;
    reply_t      r;
    n = 0;
    case (cmd)
      CMD_BUS_RESET: begin
        sl_phase    = SLV_ROM_CMD;
        sl_byte_idx = 3'd0;
      end
      CMD_WRITE: begin
        case (sl_phase)
          SLV_ROM_CMD: begin
            if (d == ROM_READ) begin
              for (int k = 0; k < 8; k++) begin
                bytes_out[k] = cfg_rom_id[8 * k +: 8];
              end
              n = 8;
              sl_phase = SLV_IDLE;
            end else if (d == ROM_MATCH) begin
              sl_byte_idx = 3'd0;
              sl_id_ok    = 1'b1;
              sl_phase    = SLV_MATCH;
            end else if (d == ROM_SKIP) begin
              sl_phase = SLV_FUNC_CMD;
            end else begin
              sl_phase = SLV_IDLE;
            end
          end
          SLV_MATCH: begin
            if (d != cfg_rom_id[8 * sl_byte_idx +: 8]) begin
              sl_id_ok = 1'b0;
            end
            if (sl_byte_idx == 3'd7) begin
              sl_byte_idx = 3'd0;
              sl_phase = sl_id_ok ? SLV_FUNC_CMD : SLV_IDLE;
            end else begin
              sl_byte_idx = sl_byte_idx + 3'd1;
            end
          end
          SLV_FUNC_CMD: begin
            if (d == FN_WRITE) begin
              sl_phase = SLV_WADDR_LO;
            end else if (d == FN_READ) begin
              sl_phase = SLV_RADDR_LO;
            end else if (d == FN_CONVERT) begin
              sl_phase = SLV_CONV_CH;
            end else begin
              sl_phase = SLV_IDLE;
            end
          end
          SLV_WADDR_LO: begin
            sl_addr_lo = d;
            sl_phase   = SLV_WADDR_HI;
          end
          SLV_WADDR_HI: begin
            sl_addr  = {d, sl_addr_lo};
            sl_phase = SLV_WDATA;
          end
          SLV_WDATA: begin
            // Bytes past the store are dropped but still echoed with CRC.
            a = sl_addr;
            if (a < STORE_BYTES) begin
              sl_store[a] = d;
            end
            sl_addr = a + 16'd1;
            crc = crc_fold(16'h0000, FN_WRITE);
            crc = crc_fold(crc, a[7:0]);
            crc = crc_fold(crc, a[15:8]);
            crc = crc_fold(crc, d);
            bytes_out[0] = crc[7:0];
            bytes_out[1] = crc[15:8];
            bytes_out[2] = ~crc[7:0];
            n = 3;
          end
          SLV_RADDR_LO: begin
            sl_addr_lo = d;
            sl_phase   = SLV_RADDR_HI;
          end
          SLV_RADDR_HI: begin
            // Eight bytes without address wrap, ones past the store, then the
            // inverted CRC over command, address and data.
            a = {d, sl_addr_lo};
            crc = crc_fold(16'h0000, FN_READ);
            crc = crc_fold(crc, sl_addr_lo);
            crc = crc_fold(crc, d);
            for (int k = 0; k < 8; k++) begin
              pos = int'(a) + k;
              b = (pos < STORE_BYTES) ? sl_store[pos] : BYTE_ONES;
              bytes_out[k] = b;
              crc = crc_fold(crc, b);
            end
            bytes_out[8] = ~crc[7:0];
            bytes_out[9] = ~crc[15:8];
            n = 10;
            sl_phase = SLV_IDLE;
          end
          SLV_CONV_CH: begin
            sl_channel = d;
            sl_phase   = SLV_CONV_CTRL;
          end
          SLV_CONV_CTRL: begin
            crc = crc_fold(16'h0000, FN_CONVERT);
            crc = crc_fold(crc, sl_channel);
            crc = crc_fold(crc, d);
            bytes_out[0] = crc[7:0];
            bytes_out[1] = crc[15:8];
            n = 2;
            sl_conv_cnt  = 16'h0000;
            sl_conv_done = 1'b0;
            sl_phase     = SLV_POLL;
          end
          default: begin
            // Idle and polling ignore written bytes.
          end
        endcase
      end
      CMD_READ: begin
        if (sl_phase == SLV_POLL) begin
          if (sl_conv_cnt >= cfg_conv_ticks) begin
            sl_conv_done = 1'b1;
          end
          bytes_out[0] = sl_conv_done ? BYTE_ONES : BYTE_ZERO;
          if (sl_conv_done) begin
            sl_phase = SLV_IDLE;
          end
        end else begin
          bytes_out[0] = BYTE_ONES;
        end
        n = 1;
      end
      default: begin
        // Timer tick: sweep prescaler, then the saturating conversion counter.
        sl_sweep_cnt = sl_sweep_cnt + 17'd1;
        if (sl_sweep_cnt >= {1'b0, cfg_sweep_ticks}) begin
          sl_sweep_cnt = 17'd0;
          if (sl_rising) begin
            if (sl_level < LEVEL_CAP) begin
              sl_level = sl_level + 13'd1;
            end
          end else begin
            if (sl_level != 13'd0) begin
              sl_level = sl_level - 13'd1;
            end
          end
          // The lower turning point is tested last, so it wins when the
          // limits cross.
          if (sl_level >= cfg_sweep_max) begin
            sl_rising = 1'b0;
          end
          if (sl_level <= cfg_sweep_min) begin
            sl_rising = 1'b1;
          end
          load_adc_bytes();
        end
        if (sl_conv_cnt != 16'hFFFF) begin
          sl_conv_cnt = sl_conv_cnt + 16'd1;
        end
        if (sl_conv_cnt >= cfg_conv_ticks) begin
          sl_conv_done = 1'b1;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      r.data = bytes_out[k];
      r.last = (k == n - 1);
      reply_q.push_back(r);
    end
  endtask

  // Presents one item at the falling edge, with random idle cycles ahead of
  // it, and waits for the rising edge that accepts it. The model is advanced
  // at that edge; a typed row replaces the predicted reply with its own.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic typed, input logic [7:0] typed_byte);
    int     n0;
    reply_t r;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 16) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    n0 = reply_q.size();
    predict_reply(cmd, data);
    if (typed) begin
      while (reply_q.size() > n0) void'(reply_q.pop_back());
      r.data = typed_byte;
      r.last = 1'b1;
      reply_q.push_back(r);
    end
  endtask

  task automatic drive(input logic [1:0] cmd, input logic [7:0] data);
    send_item(cmd, data, 1'b0, BYTE_ZERO);
  endtask

  // Lowers tvalid, waits for every predicted reply, then lets the engine
  // finish any work that has no reply (a tick with a sweep step).
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write while the engine is quiet; the model follows at once.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    case (idx)
      CFG_ROM_ID:      cfg_rom_id      = val;
      CFG_CONV_TICKS:  cfg_conv_ticks  = val[15:0];
      CFG_SWEEP_TICKS: cfg_sweep_ticks = val[15:0];
      CFG_SWEEP_MIN:   cfg_sweep_min   = val[12:0];
      CFG_SWEEP_MAX:   cfg_sweep_max   = val[12:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Memory addresses: mostly inside or just past the store, 28 just above
  // that range, the top of the space (wrap) and anything at all.
  function automatic logic [15:0] pick_address();
    int p;
    p = $urandom_range(99);
    if (p < 55) begin
      return 16'($urandom_range(27));
    end else if (p < 65) begin
      return 16'h001C;
    end else if (p < 80) begin
      return 16'hFFF8 + 16'($urandom_range(7));
    end else begin
      return 16'($urandom);
    end
  endfunction

  // One bus session: reset, a ROM command, then mostly a function command
  // with random content. A few sessions carry a corrupted identity byte or an
  // unknown command.
  task automatic run_session();
    int          pick;
    int          bad_pos;
    logic [15:0] addr;
    logic [7:0]  b;
    drive(CMD_BUS_RESET, 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 45) begin
      drive(CMD_WRITE, ROM_SKIP);
    end else if (pick < 80) begin
      drive(CMD_WRITE, ROM_MATCH);
      bad_pos = ($urandom_range(99) < 15) ? $urandom_range(7) : 8;
      for (int k = 0; k < 8; k++) begin
        b = cfg_rom_id[8 * k +: 8];
        if (k == bad_pos) begin
          b = b ^ (8'h01 << $urandom_range(7));
        end
        drive(CMD_WRITE, b);
      end
    end else if (pick < 90) begin
      drive(CMD_WRITE, ROM_READ);
      if ($urandom_range(1) == 0) begin
        drive(CMD_READ, 8'($urandom));
      end
      return;
    end else begin
      drive(CMD_WRITE, 8'($urandom));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      drive(CMD_WRITE, FN_WRITE);
      addr = pick_address();
      drive(CMD_WRITE, addr[7:0]);
      drive(CMD_WRITE, addr[15:8]);
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(9) == 0) begin
          drive(CMD_READ, 8'($urandom));
        end else begin
          drive(CMD_WRITE, 8'($urandom));
        end
      end
    end else if (pick < 70) begin
      drive(CMD_WRITE, FN_READ);
      addr = pick_address();
      drive(CMD_WRITE, addr[7:0]);
      drive(CMD_WRITE, addr[15:8]);
    end else if (pick < 95) begin
      drive(CMD_WRITE, FN_CONVERT);
      drive(CMD_WRITE, 8'($urandom));
      drive(CMD_WRITE, 8'($urandom));
      // Polling: read slots and ticks interleaved.
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(1) == 0) begin
          drive(CMD_READ, 8'($urandom));
        end else begin
          drive(CMD_TICK, 8'($urandom));
        end
      end
    end else begin
      drive(CMD_WRITE, 8'($urandom));
    end
  endtask

  // Random stimulus: mostly whole sessions, some raw noise, some tick bursts.
  task automatic run_random(input int n_items);
    int stop;
    int pick;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_session();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) drive(2'($urandom_range(3)), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 20)) drive(CMD_TICK, 8'($urandom));
      end
    end
  endtask

  // The output side stalls at random except during the no-idle stretch.
  always @(negedge clk_i) begin
    m_axis_tready = no_idle || ($urandom_range(99) >= 16);
  end

  // Reply checker: every accepted output item is matched against the oldest
  // predicted byte, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: reply with none predicted: data %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = reply_q.pop_front();
        replies_checked++;
        if (m_axis_tdata !== want.data) begin
          $display("%0t: data mismatch: expected %h actual %h",
                   $time, want.data, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: tlast mismatch: expected %b actual %b",
                   $time, want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, reply_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = CMD_BUS_RESET;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ROM_ID;
    cfg_data_i    = 64'h0;
    error_count     = 0;
    items_sent      = 0;
    replies_checked = 0;
    reg_writes      = 0;
    cycle_count     = 0;
    no_idle         = 1'b0;

    // Directed part, run with the reset register values. Typed rows are
    // replies that need no model: a read slot outside polling gives ones, a
    // poll right after convert gives zeros.
    directed_rows = '{
      {CMD_READ,      8'h00,      1'b1, BYTE_ONES},  // read slot after reset
      {CMD_WRITE,     8'h00,      1'b0, BYTE_ZERO},  // written bytes in idle
      {CMD_WRITE,     8'hFF,      1'b0, BYTE_ZERO},  //   are ignored
      {CMD_TICK,      8'hFF,      1'b0, BYTE_ZERO},
      {CMD_BUS_RESET, 8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     ROM_READ,   1'b0, BYTE_ZERO},  // eight identity bytes
      {CMD_READ,      8'hFF,      1'b1, BYTE_ONES},
      {CMD_BUS_RESET, 8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     ROM_SKIP,   1'b0, BYTE_ZERO},
      {CMD_WRITE,     FN_READ,    1'b0, BYTE_ZERO},
      {CMD_WRITE,     8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     8'h00,      1'b0, BYTE_ZERO},  // store bytes 0..7 + CRC
      {CMD_BUS_RESET, 8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     ROM_SKIP,   1'b0, BYTE_ZERO},
      {CMD_WRITE,     FN_WRITE,   1'b0, BYTE_ZERO},
      {CMD_WRITE,     8'h17,      1'b0, BYTE_ZERO},  // last store address
      {CMD_WRITE,     8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     8'hFF,      1'b0, BYTE_ZERO},  // stored
      {CMD_WRITE,     8'h5A,      1'b0, BYTE_ZERO},  // past the store, dropped
      {CMD_BUS_RESET, 8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     ROM_SKIP,   1'b0, BYTE_ZERO},
      {CMD_WRITE,     FN_CONVERT, 1'b0, BYTE_ZERO},
      {CMD_WRITE,     8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     8'hFF,      1'b0, BYTE_ZERO},  // CRC of the convert
      {CMD_READ,      8'h00,      1'b1, BYTE_ZERO},  // conversion still busy
      {CMD_BUS_RESET, 8'h00,      1'b0, BYTE_ZERO},
      {CMD_WRITE,     8'h99,      1'b0, BYTE_ZERO},  // unknown ROM command
      {CMD_READ,      8'h00,      1'b1, BYTE_ONES}
    };

    reset_slave_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].typed_byte);
    end
    wait_drained();

    // Fastest timing and the widest sweep window.
    write_reg(CFG_ROM_ID, {$urandom, $urandom});
    write_reg(CFG_CONV_TICKS, 64'd1);
    write_reg(CFG_SWEEP_TICKS, 64'd1);
    write_reg(CFG_SWEEP_MIN, 64'd0);
    write_reg(CFG_SWEEP_MAX, 64'(LEVEL_CAP));
    run_random(70);
    wait_drained();

    // Slowest timing, all-ones identity, crossed sweep limits.
    write_reg(CFG_ROM_ID, {64{1'b1}});
    write_reg(CFG_CONV_TICKS, 64'd65535);
    write_reg(CFG_SWEEP_TICKS, 64'd65535);
    write_reg(CFG_SWEEP_MIN, 64'(LEVEL_CAP));
    write_reg(CFG_SWEEP_MAX, 64'd0);
    run_random(60);
    wait_drained();

    // Long stretch with no idling on either side: a random setting, then
    // short single-step tick bursts with both limits at each end.
    no_idle = 1'b1;
    write_reg(CFG_ROM_ID, 64'd0);
    write_reg(CFG_CONV_TICKS, 64'($urandom_range(1, 24)));
    write_reg(CFG_SWEEP_TICKS, 64'($urandom_range(1, 3)));
    write_reg(CFG_SWEEP_MIN, 64'($urandom_range(0, 6553)));
    write_reg(CFG_SWEEP_MAX, 64'($urandom_range(0, 6553)));
    run_random(70);
    for (int s = 0; s < 2; s++) begin
      wait_drained();
      // Both limits at the cap turn the sweep upward; both at zero turn it
      // downward.
      write_reg(CFG_SWEEP_TICKS, 64'd1);
      write_reg(CFG_SWEEP_MIN, (s == 0) ? 64'(LEVEL_CAP) : 64'd0);
      write_reg(CFG_SWEEP_MAX, (s == 0) ? 64'(LEVEL_CAP) : 64'd0);
      repeat (16) drive(CMD_TICK, 8'($urandom));
      drive(CMD_BUS_RESET, 8'h00);
      drive(CMD_WRITE, ROM_SKIP);
      drive(CMD_WRITE, FN_READ);
      drive(CMD_WRITE, 8'h00);
      drive(CMD_WRITE, 8'h00);
    end
    wait_drained();
    no_idle = 1'b0;

    // Short conversions, quick sweep in a low window.
    write_reg(CFG_ROM_ID, {$urandom, $urandom});
    write_reg(CFG_CONV_TICKS, 64'($urandom_range(1, 10)));
    write_reg(CFG_SWEEP_TICKS, 64'($urandom_range(1, 5)));
    write_reg(CFG_SWEEP_MIN, 64'($urandom_range(0, 100)));
    write_reg(CFG_SWEEP_MAX, 64'($urandom_range(0, 200)));
    run_random(70);
    wait_drained();

    $display("Sent %0d bus events over %0d register writes; %0d reply bytes checked.",
             items_sent, reg_writes, replies_checked);
    $display("Covered ROM read/match/skip, memory write and read, convert polling, level sweep.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
